// File: src/frs_pkg.sv
package frs_pkg;

  localparam int CHILDREN_DEF = 16;
  localparam int HISTORY_DEF  = 16;
  localparam int UW           = 7;   // unit index / count width, covers up to 127 units
  localparam logic [15:0] WINDOW_DEFAULT = 16'd60;

  localparam logic [2:0] REG_STRATEGY = 3'd0;
  localparam logic [2:0] REG_LIMIT    = 3'd1;
  localparam logic [2:0] REG_WINDOW   = 3'd2;
  localparam logic [2:0] REG_UNITS    = 3'd3;
  localparam logic [2:0] REG_NEVER    = 3'd4;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_FAIL  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] STRAT_ONE   = 2'd0;
  localparam logic [1:0] STRAT_ALL   = 2'd1;
  localparam logic [1:0] STRAT_LATER = 2'd2;

  localparam logic [1:0] MODE_STOPPED   = 2'd0;
  localparam logic [1:0] MODE_RUNNING   = 2'd1;
  localparam logic [1:0] MODE_ESCALATED = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_REJECT   = 2'd1;
  localparam logic [1:0] STAT_ESCALATE = 2'd2;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_STOP     = 2'd1,
    ACT_FAIL_ESC = 2'd2,
    ACT_FAIL_RST = 2'd3
  } act_t;

  typedef struct packed {
    logic          en;
    act_t          act;
    logic [UW-1:0] ui;
    logic [UW-1:0] lo;
    logic [UW-1:0] hi;
    logic [UW-1:0] n;
  } unit_ctrl_t;

endpackage

// File: src/frs_hist_cell.sv
module frs_hist_cell (
  input  logic        clk,
  input  logic        log_en,
  input  logic        rot_en,
  input  logic [31:0] shift_in,
  input  logic [31:0] rot_in,
  output logic [31:0] ts
);
  logic [31:0] ts_r;

  // A new timestamp pushes the line one place down; a scan rotates it one place up.
  always_ff @(posedge clk) begin
    if (log_en) begin
      ts_r <= shift_in;
    end else if (rot_en) begin
      ts_r <= rot_in;
    end
  end

  assign ts = ts_r;
endmodule

// File: src/frs_unit_cell.sv
module frs_unit_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  frs_pkg::unit_ctrl_t ctrl,
  input  logic              never_bit,
  output logic              running,
  output logic [15:0]       restarts,
  output logic [15:0]       streak
);
  import frs_pkg::*;

  localparam logic [UW-1:0] MY_IDX = UW'(IDX);

  logic        run_r, run_nxt;
  logic [15:0] rc_r, rc_nxt;
  logic [15:0] st_r, st_nxt;
  logic        in_n, is_ui, in_range;

  assign in_n     = MY_IDX < ctrl.n;
  assign is_ui    = MY_IDX == ctrl.ui;
  assign in_range = (MY_IDX >= ctrl.lo) && (MY_IDX < ctrl.hi);

  always_comb begin
    run_nxt = run_r;
    rc_nxt  = rc_r;
    st_nxt  = st_r;
    if (ctrl.en) begin
      case (ctrl.act)
        ACT_START: begin
          if (in_n) run_nxt = 1'b1;
        end
        ACT_STOP: begin
          if (in_n) run_nxt = 1'b0;
        end
        ACT_FAIL_ESC: begin
          if (is_ui) begin
            run_nxt = 1'b0;
            if (st_r != 16'hFFFF) st_nxt = st_r + 16'd1;
          end
          if (in_n) run_nxt = 1'b0;
        end
        ACT_FAIL_RST: begin
          if (is_ui) begin
            run_nxt = 1'b0;
            if (st_r != 16'hFFFF) st_nxt = st_r + 16'd1;
          end
          if (in_range) begin
            run_nxt = 1'b0;
            if (!never_bit) begin
              if (rc_r != 16'hFFFF) rc_nxt = rc_r + 16'd1;
              run_nxt = 1'b1;
              st_nxt  = 16'd0;
            end
          end
        end
        default: begin
          run_nxt = run_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      rc_r  <= 16'd0;
      st_r  <= 16'd0;
    end else begin
      run_r <= run_nxt;
      rc_r  <= rc_nxt;
      st_r  <= st_nxt;
    end
  end

  assign running  = run_r;
  assign restarts = rc_r;
  assign streak   = st_r;
endmodule

// File: src/fault_restart_supervisor_core.sv
// Fault restart supervisor.
// Input beats carry a command (start all, stop all, unit failed, query),
// a unit index and the current time in seconds. Every input beat yields
// exactly one output beat with status, mode, running mask, counters and
// the number of logged failures inside the window.
// A failure timestamp is pushed into a line of HISTORY cells. Every event
// then rotates that line once around, one cell per cycle, comparing the
// head cell against the window cutoff. The decide state follows the scan,
// and out_tvalid rises in the output state after it. The unit state lives
// in CHILDREN cells that all update in the decide cycle.
// One event is in flight at a time: in_tready is high only while idle.
// When the receiver stalls, the output beat is held until out_tready.
// Reset clears mode, running units, counters and the ring fill; the
// configuration registers return to their reset values (window 60 s).
// The user must write configuration over the APB port only while the
// block is idle; the block itself does not enforce this.
module fault_restart_supervisor_core #(
  parameter int CHILDREN = frs_pkg::CHILDREN_DEF,
  parameter int HISTORY  = frs_pkg::HISTORY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], unit_index[5:2], now_seconds[37:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // status[1:0], supervisor_mode[3:2], running_mask[19:4],
                                  // total_failures[51:20], unit_restarts[67:52],
                                  // unit_consecutive_failures[83:68],
                                  // recent_failures[88:84], escalate_pulse[89]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import frs_pkg::*;

  localparam int CW = $clog2(HISTORY + 1);
  localparam logic [CW-1:0] HIST_LAST = CW'(HISTORY - 1);
  localparam logic [CW-1:0] HIST_FULL = CW'(HISTORY);
  localparam logic [UW-1:0] CHILD_N   = UW'(CHILDREN);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  // Configuration registers.
  logic [1:0]  strat_r;
  logic [7:0]  limit_r;
  logic [15:0] window_r;
  logic [4:0]  units_r;
  logic [15:0] never_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strat_r  <= 2'd0;
      limit_r  <= 8'd0;
      window_r <= WINDOW_DEFAULT;
      units_r  <= 5'd0;
      never_r  <= 16'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_STRATEGY: strat_r  <= cfg_pwdata[1:0];
        REG_LIMIT:    limit_r  <= cfg_pwdata[7:0];
        REG_WINDOW:   window_r <= cfg_pwdata[15:0];
        REG_UNITS:    units_r  <= cfg_pwdata[4:0];
        REG_NEVER:    never_r  <= cfg_pwdata[15:0];
        default:      strat_r  <= strat_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_STRATEGY: cfg_prdata = {30'd0, strat_r};
      REG_LIMIT:    cfg_prdata = {24'd0, limit_r};
      REG_WINDOW:   cfg_prdata = {16'd0, window_r};
      REG_UNITS:    cfg_prdata = {27'd0, units_r};
      REG_NEVER:    cfg_prdata = {16'd0, never_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // Input fields.
  logic [1:0]  in_cmd;
  logic [3:0]  in_ui;
  logic [31:0] in_now;
  assign in_cmd = in_tdata[1:0];
  assign in_ui  = in_tdata[5:2];
  assign in_now = in_tdata[37:6];

  state_t         state_r, state_nxt;
  logic [1:0]     cmd_r;
  logic [3:0]     ui_r;
  logic [UW-1:0]  n_r;
  logic           fail_ok_r;
  logic           cut_all_r;
  logic [31:0]    cutoff_r;
  logic [CW-1:0]  step_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  fill_r;
  logic [31:0]    total_r;
  logic [1:0]     mode_r;
  logic [1:0]     status_r;
  logic           pulse_r;

  logic           accept;
  logic [UW-1:0]  n_now;
  logic [UW-1:0]  ui_ext;
  logic           fail_ok_now;
  logic [15:0]    win;
  logic           hit;
  logic           escalate;
  logic [31:0]    cnt32;
  logic [31:0]    head_ts;

  assign accept      = in_tvalid && in_tready;
  assign in_tready   = state_r == ST_IDLE;
  assign out_tvalid  = state_r == ST_OUT;
  assign n_now       = ({2'd0, units_r} < CHILD_N) ? UW'(units_r) : CHILD_N;
  assign ui_ext      = UW'(in_ui);
  assign fail_ok_now = (in_cmd == CMD_FAIL) && (ui_ext < n_now) && (mode_r == MODE_RUNNING);
  assign win         = (window_r == 16'd0) ? WINDOW_DEFAULT : window_r;
  assign cnt32       = 32'(cnt_r);
  assign escalate    = fail_ok_r && (limit_r != 8'd0) && (cnt32 > 32'(limit_r));

  // Timestamp line.
  logic [31:0] ts [HISTORY];
  logic        log_en, rot_en;
  assign log_en = accept && fail_ok_now;
  assign rot_en = state_r == ST_SCAN;

  for (genvar h = 0; h < HISTORY; h++) begin : g_hist
    frs_hist_cell u_cell (
      .clk      (clk),
      .log_en   (log_en),
      .rot_en   (rot_en),
      .shift_in ((h == 0) ? in_now : ts[(h == 0) ? 0 : h - 1]),
      .rot_in   (ts[(h + 1) % HISTORY]),
      .ts       (ts[h])
    );
  end

  assign head_ts = ts[0];
  assign hit     = (step_r < fill_r) && (cut_all_r || (head_ts >= cutoff_r));

  // Unit cells.
  unit_ctrl_t  ctrl;
  logic        run_v [CHILDREN];
  logic [15:0] rc_v  [CHILDREN];
  logic [15:0] st_v  [CHILDREN];
  logic [15:0] run16;
  logic [15:0] rc16  [16];
  logic [15:0] st16  [16];

  always_comb begin
    ctrl.en  = 1'b0;
    ctrl.act = ACT_START;
    ctrl.ui  = UW'(ui_r);
    ctrl.lo  = '0;
    ctrl.hi  = '0;
    ctrl.n   = n_r;
    if (state_r == ST_DECIDE) begin
      case (cmd_r)
        CMD_START: begin
          ctrl.en  = mode_r != MODE_RUNNING;
          ctrl.act = ACT_START;
        end
        CMD_STOP: begin
          ctrl.en  = mode_r != MODE_STOPPED;
          ctrl.act = ACT_STOP;
        end
        CMD_FAIL: begin
          ctrl.en  = fail_ok_r;
          ctrl.act = escalate ? ACT_FAIL_ESC : ACT_FAIL_RST;
          case (strat_r)
            STRAT_ONE: begin
              ctrl.lo = UW'(ui_r);
              ctrl.hi = UW'(ui_r) + UW'(1);
            end
            STRAT_ALL: begin
              ctrl.lo = '0;
              ctrl.hi = n_r;
            end
            STRAT_LATER: begin
              ctrl.lo = UW'(ui_r);
              ctrl.hi = n_r;
            end
            default: begin
              ctrl.lo = '0;
              ctrl.hi = '0;
            end
          endcase
        end
        default: begin
          ctrl.en = 1'b0;
        end
      endcase
    end
  end

  for (genvar c = 0; c < CHILDREN; c++) begin : g_unit
    logic never_bit;
    if (c < 16) begin : g_mask
      assign never_bit = never_r[c];
    end else begin : g_nomask
      assign never_bit = 1'b0;
    end
    frs_unit_cell #(.IDX(c)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .never_bit (never_bit),
      .running   (run_v[c]),
      .restarts  (rc_v[c]),
      .streak    (st_v[c])
    );
  end

  for (genvar v = 0; v < 16; v++) begin : g_view
    if (v < CHILDREN) begin : g_have
      assign run16[v] = run_v[v];
      assign rc16[v]  = rc_v[v];
      assign st16[v]  = st_v[v];
    end else begin : g_none
      assign run16[v] = 1'b0;
      assign rc16[v]  = 16'd0;
      assign st16[v]  = 16'd0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (step_r == HIST_LAST) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_OUT;
      ST_OUT:    if (out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mode_r   <= MODE_STOPPED;
      fill_r   <= '0;
      total_r  <= 32'd0;
      status_r <= STAT_OK;
      pulse_r  <= 1'b0;
      step_r   <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r <= '0;
        cnt_r  <= '0;
        if (fail_ok_now) begin
          if (fill_r != HIST_FULL) fill_r <= fill_r + CW'(1);
          if (total_r != 32'hFFFF_FFFF) total_r <= total_r + 32'd1;
        end
      end
      if (state_r == ST_SCAN) begin
        step_r <= step_r + CW'(1);
        cnt_r  <= cnt_r + CW'(hit);
      end
      if (state_r == ST_DECIDE) begin
        status_r <= STAT_OK;
        pulse_r  <= 1'b0;
        case (cmd_r)
          CMD_START: mode_r <= MODE_RUNNING;
          CMD_STOP:  mode_r <= MODE_STOPPED;
          CMD_FAIL: begin
            if (!fail_ok_r) begin
              status_r <= STAT_REJECT;
            end else if (escalate) begin
              mode_r   <= MODE_ESCALATED;
              status_r <= STAT_ESCALATE;
              pulse_r  <= 1'b1;
            end
          end
          default: begin
            if (UW'(ui_r) >= n_r) status_r <= STAT_REJECT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_cmd;
      ui_r      <= in_ui;
      n_r       <= n_now;
      fail_ok_r <= fail_ok_now;
      cut_all_r <= in_now < {16'd0, win};
      cutoff_r  <= in_now - {16'd0, win};
    end
  end

  assign out_tdata = {6'd0, pulse_r, cnt32[4:0], st16[ui_r], rc16[ui_r], total_r,
                      run16, mode_r, status_r};

  a_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && pulse_r |-> mode_r == MODE_ESCALATED && status_r == STAT_ESCALATE)
    else $error("escalate pulse without escalated mode");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= HIST_FULL)
    else $error("ring fill beyond depth");
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_tvalid && state_r == ST_SCAN)
    else $error("output valid right after accept");
  a_cnt_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DECIDE |-> cnt_r <= fill_r)
    else $error("recent count above ring fill");

endmodule

// File: tb/fault_restart_supervisor_checker.sv
`timescale 1ns / 1ps

module fault_restart_supervisor_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          awaiting
);
  import frs_pkg::*;

  // Members run from the highest bit down, so status lands in the lowest bits.
  typedef struct packed {
    logic        pulse;
    logic [4:0]  recent;
    logic [15:0] streak;
    logic [15:0] restarts;
    logic [31:0] total;
    logic [15:0] mask;
    logic [1:0]  mode;
    logic [1:0]  status;
  } verdict_t;

  // Shadow configuration.
  logic [1:0]  strategy;
  logic [7:0]  limit;
  logic [15:0] window;
  logic [4:0]  units;
  logic [15:0] never_mask;

  // Shadow supervisor state.
  logic [1:0]  mode;
  logic [15:0] running;
  logic [15:0] restart_cnt [16];
  logic [15:0] streak_cnt  [16];
  logic [31:0] stamp_ring  [16];
  logic [3:0]  head;
  logic [4:0]  fill;
  logic [31:0] fail_total;

  verdict_t expected_beats[$];

  assign awaiting = expected_beats.size();

  function automatic logic [4:0] recent_in_window(logic [31:0] now);
    longint cutoff;
    logic [4:0] hits;
    logic [3:0] slot;
    cutoff = longint'({32'd0, now}) - longint'({48'd0, (window == 0) ? WINDOW_DEFAULT : window});
    hits = 0;
    for (int k = 0; k < 16; k++) begin
      slot = head + k[3:0];
      if (k < fill && longint'({32'd0, stamp_ring[slot]}) >= cutoff) hits++;
    end
    return hits;
  endfunction

  task automatic restart_units(int lo, int hi);
    for (int i = lo; i < hi; i++) begin
      running[i] = 1'b0;
      if (!never_mask[i]) begin
        if (restart_cnt[i] != 16'hFFFF) restart_cnt[i]++;
        running[i] = 1'b1;
        streak_cnt[i] = 16'd0;
      end
    end
  endtask

  task automatic apply_event(logic [1:0] cmd, logic [3:0] ui, logic [31:0] now,
                             output verdict_t v);
    int n;
    n = (units > 16) ? 16 : units;
    v = '0;
    v.status = STAT_OK;
    case (cmd)
      CMD_START: begin
        if (mode != MODE_RUNNING) begin
          mode = MODE_RUNNING;
          for (int i = 0; i < n; i++) running[i] = 1'b1;
        end
      end
      CMD_STOP: begin
        if (mode != MODE_STOPPED) begin
          for (int i = 0; i < n; i++) running[i] = 1'b0;
          mode = MODE_STOPPED;
        end
      end
      CMD_FAIL: begin
        if (ui >= n || mode != MODE_RUNNING) begin
          v.status = STAT_REJECT;
        end else begin
          running[ui] = 1'b0;
          if (streak_cnt[ui] != 16'hFFFF) streak_cnt[ui]++;
          stamp_ring[head + fill[3:0]] = now;
          if (fill < 16) fill++;
          else head++;
          if (fail_total != 32'hFFFF_FFFF) fail_total++;
          if (limit != 0 && recent_in_window(now) > limit) begin
            mode = MODE_ESCALATED;
            for (int i = 0; i < n; i++) running[i] = 1'b0;
            v.status = STAT_ESCALATE;
            v.pulse = 1'b1;
          end else begin
            case (strategy)
              STRAT_ONE:   if (!never_mask[ui]) restart_units(ui, ui + 1);
              STRAT_ALL:   restart_units(0, n);
              STRAT_LATER: restart_units(ui, n);
              default: ;  // unknown strategy leaves the failed unit down
            endcase
          end
        end
      end
      default: begin
        if (ui >= n) v.status = STAT_REJECT;
      end
    endcase
    v.mode = mode;
    v.mask = running;
    v.total = fail_total;
    v.restarts = restart_cnt[ui];
    v.streak = streak_cnt[ui];
    v.recent = recent_in_window(now);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    verdict_t v;
    verdict_t got;
    if (!rst_n) begin
      strategy = STRAT_ONE;
      limit = 0;
      window = WINDOW_DEFAULT;
      units = 0;
      never_mask = 0;
      mode = MODE_STOPPED;
      running = 0;
      for (int i = 0; i < 16; i++) begin
        restart_cnt[i] = 16'd0;
        streak_cnt[i] = 16'd0;
        stamp_ring[i] = 32'd0;
      end
      head = 0;
      fill = 0;
      fail_total = 0;
      expected_beats.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_STRATEGY: strategy = cfg_pwdata[1:0];
          REG_LIMIT:    limit = cfg_pwdata[7:0];
          REG_WINDOW:   window = cfg_pwdata[15:0];
          REG_UNITS:    units = cfg_pwdata[4:0];
          REG_NEVER:    never_mask = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      // Pop before push: a beat leaving now cannot belong to one entering now.
      if (out_tvalid && out_tready) begin
        got = out_tdata[89:0];
        if (expected_beats.size() == 0) begin
          $error("output beat with no event outstanding");
          fail_count++;
        end else begin
          v = expected_beats.pop_front();
          check_field("status", 32'(v.status), 32'(got.status));
          check_field("supervisor_mode", 32'(v.mode), 32'(got.mode));
          check_field("running_mask", 32'(v.mask), 32'(got.mask));
          check_field("total_failures", v.total, got.total);
          check_field("unit_restarts", 32'(v.restarts), 32'(got.restarts));
          check_field("unit_consecutive_failures", 32'(v.streak), 32'(got.streak));
          check_field("recent_failures", 32'(v.recent), 32'(got.recent));
          check_field("escalate_pulse", 32'(v.pulse), 32'(got.pulse));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_event(in_tdata[1:0], in_tdata[5:2], in_tdata[37:6], v);
        expected_beats.push_back(v);
      end
    end
  end

endmodule

// File: tb/fault_restart_supervisor_core_test.sv
`timescale 1ns / 1ps

module fault_restart_supervisor_core_test;
  import frs_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          fail_count;
  int          awaiting;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [31:0] clock_now = 0;

  fault_restart_supervisor_core dut (.*);

  fault_restart_supervisor_checker scoreboard (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver stall behavior rotates among three styles over simulation time.
  always @(posedge clk) begin
    int style;
    style = int'(($time / 1600) % 3);
    case (style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_event(logic [1:0] cmd, logic [3:0] ui, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, now, ui, cmd};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] strat, logic [7:0] lim, logic [15:0] win,
                           logic [4:0] nunits, logic [15:0] never_mask);
    wait_idle();
    write_reg(REG_STRATEGY, 32'(strat));
    write_reg(REG_LIMIT, 32'(lim));
    write_reg(REG_WINDOW, 32'(win));
    write_reg(REG_UNITS, 32'(nunits));
    write_reg(REG_NEVER, 32'(never_mask));
  endtask

  task automatic random_phase(int count, int span);
    logic [1:0] cmd;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      cmd = (pick < 50) ? CMD_FAIL : (pick < 70) ? CMD_QUERY :
            (pick < 85) ? CMD_START : CMD_STOP;
      if ($urandom_range(0, 19) == 0) clock_now = $urandom();
      else clock_now = clock_now + $urandom_range(0, span);
      send_event(cmd, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 7)), clock_now);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle-state commands, double start, escalation and restart.
    configure(STRAT_LATER, 8'd2, 16'd10, 5'd16, 16'h0005);
    send_event(CMD_QUERY, 4'd15, 32'd0);
    send_event(CMD_STOP, 4'd0, 32'd0);
    send_event(CMD_FAIL, 4'd3, 32'd0);
    send_event(CMD_START, 4'd0, 32'd0);
    send_event(CMD_START, 4'd0, 32'd0);
    send_event(CMD_FAIL, 4'd0, 32'd0);
    send_event(CMD_FAIL, 4'd2, 32'd1);
    send_event(CMD_FAIL, 4'd5, 32'd5);
    send_event(CMD_FAIL, 4'd6, 32'd30);
    send_event(CMD_FAIL, 4'd7, 32'd31);
    send_event(CMD_FAIL, 4'd8, 32'd32);
    send_event(CMD_FAIL, 4'd9, 32'd33);
    send_event(CMD_QUERY, 4'd8, 32'd33);
    send_event(CMD_START, 4'd0, 32'd40);
    send_event(CMD_FAIL, 4'd15, 32'hFFFF_FFFF);
    send_event(CMD_STOP, 4'd0, 32'hFFFF_FFFF);
    send_event(CMD_STOP, 4'd0, 32'hFFFF_FFFF);

    configure(2'd3, 8'd0, 16'd0, 5'd31, 16'hAAAA);
    send_event(CMD_START, 4'd0, 32'd100);
    send_event(CMD_FAIL, 4'd4, 32'd100);
    send_event(CMD_QUERY, 4'd4, 32'd100);
    send_event(CMD_FAIL, 4'd1, 32'd200);
    send_event(CMD_QUERY, 4'd1, 32'hFFFF_FFFF);

    // Random phases across a spread of settings.
    clock_now = 0;
    configure(STRAT_ONE, 8'd0, 16'd60, 5'd16, 16'h0000);
    random_phase(60, 4);
    configure(STRAT_ALL, 8'd3, 16'd8, 5'd12, 16'($urandom()));
    random_phase(60, 3);
    configure(STRAT_LATER, 8'd255, 16'hFFFF, 5'd16, 16'($urandom()));
    random_phase(60, 4000);
    configure(2'd3, 8'd1, 16'd0, 5'd31, 16'($urandom()));
    random_phase(40, 30);
    configure(STRAT_ALL, 8'd0, 16'd1, 5'd0, 16'h0000);
    random_phase(20, 2);
    configure(2'($urandom_range(0, 2)), 8'($urandom_range(1, 6)),
              16'($urandom_range(1, 20)), 5'($urandom_range(1, 16)), 16'($urandom()));
    random_phase(80, 3);
    configure(STRAT_ONE, 8'd5, 16'hFFFF, 5'd16, 16'hFFFF);
    random_phase(60, 2);

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
